// ===== rtl/cmma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmma_pkg: shared types and constants of the channel moving average unit
// Holds window and channel sizes, derived widths, request and result
// structs, operation codes and controller states.
// ----------------------------------------------------------------------------
package cmma_pkg;

  localparam int SAMPLES  = 16;
  localparam int CHANNELS = 2;

  localparam int SAMPLE_W   = 10;
  localparam int AVG_W      = 10;
  localparam int MIN_W      = 11;
  localparam int POS_W      = $clog2(SAMPLES);
  localparam int FILL_W     = $clog2(SAMPLES + 1);
  localparam int SUM_W      = $clog2(1023 * SAMPLES + 1);
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RING_DEPTH = CHANNELS * SAMPLES;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam logic [MIN_W-1:0] NONE_MIN = MIN_W'(1024);

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic                operation;
    logic                channel;
    logic [SAMPLE_W-1:0] sample;
  } req_t;

  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic [MIN_W-1:0] minimum;
    logic [AVG_W-1:0] maximum;
    logic             window_full;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/cmma_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmma_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cmma_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/cmma_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmma_div: bit-serial restoring divider
// Shifts the running sum out one bit per cycle against the fill count and
// builds the quotient one bit per cycle; pulses done with the result.
// ----------------------------------------------------------------------------
module cmma_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cmma_pkg::SUM_W-1:0]  dividend,
  input  logic [cmma_pkg::FILL_W-1:0] divisor,
  output logic                       done,
  output logic [cmma_pkg::AVG_W-1:0]  quotient
);
  import cmma_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  dvd;
  logic [SUM_W-1:0]  quo;
  logic [FILL_W-1:0] rem;
  logic [FILL_W-1:0] dsr;
  logic [CNT_W-1:0]  count;
  logic [FILL_W:0]   shifted;
  logic [FILL_W:0]   diff;
  logic              fits;

  assign shifted  = {rem, dvd[SUM_W-1]};
  assign diff     = shifted - {1'b0, dsr};
  assign fits     = shifted >= {1'b0, dsr};
  assign quotient = quo[AVG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (count == CNT_W'(1));
      if (start) begin
        count <= CNT_W'(SUM_W);
      end else if (count != '0) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (count != '0) begin
      dvd <= {dvd[SUM_W-2:0], 1'b0};
      quo <= {quo[SUM_W-2:0], fits};
      rem <= fits ? diff[FILL_W-1:0] : shifted[FILL_W-1:0];
    end
  end

endmodule

// ===== rtl/channel_moving_average_minmax_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_moving_average_minmax_unit: per-channel moving average with min/max
// Keeps a ring of recent samples per channel, a running sum and fill count,
// and reports the floor average plus min/max once the window is full.
// ----------------------------------------------------------------------------
//
//   port group   direction  handshake            payload
//   ----------   ---------  -------------------  ---------------------------
//   request      in         in_valid / in_ready  in_req  (operation, channel,
//                                                         sample)
//   result       out        out_valid/out_ready  out_rsp (average, minimum,
//                                                         maximum, window_full)
//
// Steps: a sample request taken in the idle step goes through one ring
// read, one sum update and the bit-serial divider, which folds in the
// statistics as it finishes, then the result step loads the result. The
// next request is taken only once the controller is back in the idle step,
// so a request is not taken before the last one is through. A clear or an
// out-of-range channel goes straight to the result step.
// Reset (rst, synchronous, high) empties each window; statistics read as none.
// The result register parts the sides: a new request is taken while a result
// waits; a stalled result only holds the controller in its last step.
// ----------------------------------------------------------------------------
module channel_moving_average_minmax_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cmma_pkg::req_t  in_req,
  output logic            out_valid,
  input  logic            out_ready,
  output cmma_pkg::rsp_t  out_rsp
);
  import cmma_pkg::*;

  // controller
  state_t state;
  state_t state_next;

  // captured request
  logic                req_op;
  logic [CH_W-1:0]     req_ch;
  logic [SAMPLE_W-1:0] req_sample;
  logic                req_ok;

  // per-channel window and statistics
  logic [POS_W-1:0]  write_position [CHANNELS];
  logic [FILL_W-1:0] fill_count     [CHANNELS];
  logic [SUM_W-1:0]  running_sum    [CHANNELS];
  logic [AVG_W-1:0]  last_average   [CHANNELS];
  logic [MIN_W-1:0]  min_average    [CHANNELS];
  logic [AVG_W-1:0]  max_average    [CHANNELS];

  // datapath signals
  logic                in_fire;
  logic                slot_free;
  logic                ram_re;
  logic                ram_we;
  logic                div_start;
  logic                div_done;
  logic                stats_we;
  logic                rsp_load;
  logic [RING_AW-1:0]  ring_addr;
  logic [SAMPLE_W-1:0] ring_old;
  logic                was_full;
  logic [SUM_W-1:0]  sum_next;
  logic [FILL_W-1:0] fill_next;
  logic [POS_W-1:0]  pos_next;
  logic [AVG_W-1:0]  quotient;
  logic              full_now;

  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // Ring entry for this channel at its write position.
  assign ring_addr = RING_AW'(req_ch) * RING_AW'(SAMPLES)
                   + RING_AW'(write_position[req_ch]);

  // Once full, the oldest sample leaves the sum as the new one enters.
  assign was_full  = fill_count[req_ch] == FILL_W'(SAMPLES);
  assign sum_next  = was_full
                   ? running_sum[req_ch] - SUM_W'(ring_old) + SUM_W'(req_sample)
                   : running_sum[req_ch] + SUM_W'(req_sample);
  assign fill_next = was_full ? fill_count[req_ch] : fill_count[req_ch] + FILL_W'(1);
  assign pos_next  = (write_position[req_ch] == POS_W'(SAMPLES - 1))
                   ? '0 : write_position[req_ch] + POS_W'(1);
  assign full_now  = fill_count[req_ch] == FILL_W'(SAMPLES);

  cmma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ring_addr),
    .wdata (req_sample),
    .re    (ram_re),
    .raddr (ring_addr),
    .rdata (ring_old)
  );

  cmma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (fill_next),
    .done     (div_done),
    .quotient (quotient)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if ((int'(in_req.channel) < CHANNELS) && (in_req.operation == OP_SAMPLE)) begin
            state_next = ST_LOOKUP;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_LOOKUP: state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    stats_we  = 1'b0;
    rsp_load  = 1'b0;
    case (state)
      ST_IDLE:   in_ready  = 1'b1;
      ST_LOOKUP: ram_re    = 1'b1;
      ST_UPDATE: begin
        ram_we    = 1'b1;
        div_start = 1'b1;
      end
      ST_DIVIDE: stats_we = div_done;
      ST_FINISH: rsp_load = slot_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the request for the whole computation.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_op     <= in_req.operation;
      req_ch     <= CH_W'(in_req.channel);
      req_sample <= in_req.sample;
      req_ok     <= int'(in_req.channel) < CHANNELS;
    end
  end

  // Result register: an out-of-range channel or a clear reports "none".
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      if (!req_ok || (req_op == OP_CLEAR)) begin
        out_rsp.average     <= '0;
        out_rsp.minimum     <= NONE_MIN;
        out_rsp.maximum     <= '0;
        out_rsp.window_full <= 1'b0;
      end else begin
        out_rsp.average     <= last_average[req_ch];
        out_rsp.minimum     <= min_average[req_ch];
        out_rsp.maximum     <= max_average[req_ch];
        out_rsp.window_full <= full_now;
      end
    end
  end

  // Per-channel state: advance on a sample, fold in the new average, and
  // drop everything on a clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        write_position[c] <= '0;
        fill_count[c]     <= '0;
        running_sum[c]    <= '0;
        last_average[c]   <= '0;
        min_average[c]    <= NONE_MIN;
        max_average[c]    <= '0;
      end
    end else begin
      if (ram_we) begin
        running_sum[req_ch]    <= sum_next;
        fill_count[req_ch]     <= fill_next;
        write_position[req_ch] <= pos_next;
      end
      if (stats_we) begin
        last_average[req_ch] <= quotient;
        if (full_now) begin
          if (quotient > max_average[req_ch]) begin
            max_average[req_ch] <= quotient;
          end
          if ({1'b0, quotient} < min_average[req_ch]) begin
            min_average[req_ch] <= {1'b0, quotient};
          end
        end
      end
      if ((state == ST_FINISH) && req_ok && (req_op == OP_CLEAR)) begin
        write_position[req_ch] <= '0;
        fill_count[req_ch]     <= '0;
        running_sum[req_ch]    <= '0;
        last_average[req_ch]   <= '0;
        min_average[req_ch]    <= NONE_MIN;
        max_average[req_ch]    <= '0;
      end
    end
  end

  // The divider only reports while the controller waits for it.
  a_div_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVIDE)
    else $error("divider done outside divide step");

  // An accepted request leads straight to the ring read or the result step.
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_LOOKUP) || (state == ST_FINISH))
    else $error("unexpected step after accepted request");

  // Before the window fills, the statistics read as none.
  a_none_until_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_rsp.window_full |->
      (out_rsp.minimum == NONE_MIN) && (out_rsp.maximum == '0))
    else $error("statistics set before window full");

  // With a full window the reported average lies between minimum and maximum.
  a_avg_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.window_full |->
      ({1'b0, out_rsp.average} >= out_rsp.minimum) &&
      (out_rsp.average <= out_rsp.maximum))
    else $error("average outside min/max");

endmodule

// ===== sim/cmma_stats_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmma_stats_checker: result checker for the channel moving average unit
// Watches both handshakes, keeps its own per-channel window, running sum,
// average and min/max, and compares every result against the oldest
// predicted one. Reports the mismatch count and the results still owed.
// ----------------------------------------------------------------------------
module cmma_stats_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  cmma_pkg::req_t  in_req,
  input  logic            out_valid,
  input  logic            out_ready,
  input  cmma_pkg::rsp_t  out_rsp,
  output int              mismatches,
  output int              outstanding
);

  import cmma_pkg::*;

  logic [SAMPLE_W-1:0] ring [CHANNELS][SAMPLES];
  logic [POS_W-1:0]    wr_pos [CHANNELS];
  logic [FILL_W-1:0]   fill [CHANNELS];
  logic [SUM_W-1:0]    sum [CHANNELS];
  logic [AVG_W-1:0]    avg [CHANNELS];
  logic [MIN_W-1:0]    lo_avg [CHANNELS];
  logic [AVG_W-1:0]    hi_avg [CHANNELS];

  rsp_t predicted_stats [$];
  rsp_t want;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Apply one request to the shadow state and return the result it owes.
  function automatic rsp_t advance_channel_window(req_t r);
    rsp_t res;
    int   ch;
    int   slot;
    ch  = r.channel;
    res = '{average: '0, minimum: NONE_MIN, maximum: '0, window_full: 1'b0};
    if (ch < CHANNELS) begin
      if (r.operation == OP_CLEAR) begin
        wr_pos[ch] = '0;
        fill[ch]   = '0;
        sum[ch]    = '0;
        avg[ch]    = '0;
        lo_avg[ch] = NONE_MIN;
        hi_avg[ch] = '0;
      end else begin
        slot = wr_pos[ch];
        // Once full, the oldest reading drops out of the sum.
        if (fill[ch] == SAMPLES) begin
          sum[ch] = sum[ch] - ring[ch][slot] + r.sample;
        end else begin
          sum[ch]  = sum[ch] + r.sample;
          fill[ch] = fill[ch] + 1'b1;
        end
        ring[ch][slot] = r.sample;
        avg[ch] = AVG_W'(sum[ch] / fill[ch]);
        if (fill[ch] == SAMPLES) begin
          if (avg[ch] > hi_avg[ch]) hi_avg[ch] = avg[ch];
          if ({1'b0, avg[ch]} < lo_avg[ch]) lo_avg[ch] = {1'b0, avg[ch]};
        end
        wr_pos[ch] = POS_W'((slot + 1) % SAMPLES);
      end
      res.average     = avg[ch];
      res.minimum     = lo_avg[ch];
      res.maximum     = hi_avg[ch];
      res.window_full = (fill[ch] == SAMPLES);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wr_pos[c] = '0;
        fill[c]   = '0;
        sum[c]    = '0;
        avg[c]    = '0;
        lo_avg[c] = NONE_MIN;
        hi_avg[c] = '0;
      end
      predicted_stats.delete();
    end else begin
      if (in_valid && in_ready) begin
        predicted_stats.push_back(advance_channel_window(in_req));
      end
      if (out_valid && out_ready) begin
        if (predicted_stats.size() == 0) begin
          $error("unexpected result: average %0d minimum %0d maximum %0d window_full %0d",
                 out_rsp.average, out_rsp.minimum, out_rsp.maximum, out_rsp.window_full);
          mismatches++;
        end else begin
          want = predicted_stats.pop_front();
          if (out_rsp.average !== want.average) begin
            $error("average: expected %0d, actual %0d", want.average, out_rsp.average);
            mismatches++;
          end
          if (out_rsp.minimum !== want.minimum) begin
            $error("minimum: expected %0d, actual %0d", want.minimum, out_rsp.minimum);
            mismatches++;
          end
          if (out_rsp.maximum !== want.maximum) begin
            $error("maximum: expected %0d, actual %0d", want.maximum, out_rsp.maximum);
            mismatches++;
          end
          if (out_rsp.window_full !== want.window_full) begin
            $error("window_full: expected %0d, actual %0d",
                   want.window_full, out_rsp.window_full);
            mismatches++;
          end
        end
      end
    end
    outstanding = predicted_stats.size();
  end

endmodule

// ===== sim/channel_moving_average_minmax_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_moving_average_minmax_unit_tb: top of the moving average testbench
// Drives a directed opening (extremes, clears, window wrap) and then random
// bursts of samples per channel with clears and noise mixed in, under random
// idling on both sides and one long result hold-off. A checker beside the
// block predicts and compares; this top only makes requests and rules.
// ----------------------------------------------------------------------------
module channel_moving_average_minmax_unit_tb;

  import cmma_pkg::*;

  localparam int RANDOM_ITEMS    = 1030;
  localparam int IDLE_PERCENT    = 17;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 60;
  localparam int CYCLE_LIMIT     = 400000;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  req_t in_req;
  logic out_valid;
  logic out_ready;
  rsp_t out_rsp;

  int mismatches;
  int outstanding;
  int cycle_count = 0;

  // Shared knobs: steady turns off idling on both sides, hold_off_go asks
  // the result side for one long stall.
  bit steady      = 1'b0;
  bit hold_off_go = 1'b0;

  always #5 clk = ~clk;

  channel_moving_average_minmax_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  cmma_stats_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rsp     (out_rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("channel_moving_average_minmax_unit: mismatch");
      $finish;
    end
  end

  // Offer one request and hold it until the block takes it. Called at a
  // rising edge; returns at the edge where the request was accepted, with
  // valid still high so the next request can follow without a bubble.
  task automatic offer_request(input logic op, input logic ch,
                               input logic [SAMPLE_W-1:0] value);
    if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      // Vary the gap so it lands on every step of the divider loop.
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req.operation <= op;
    in_req.channel   <= ch;
    in_req.sample    <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Result side: random stalls, a quiet stretch, and one long hold-off that
  // backs the block up until it stops taking requests.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        stall_left  = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  initial begin : request_source
    int                  sent;
    int                  kind;
    int                  run_len;
    int                  profile;
    bit                  held;
    logic                run_ch;
    logic                ch;
    logic [SAMPLE_W-1:0] level;
    logic [SAMPLE_W-1:0] value;

    rst      = 1'b1;
    in_valid = 1'b0;
    in_req   = '0;
    held     = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: lowest and highest readings, clear on a one-sample
    // channel with a nonzero sample field, fill a window with full-scale
    // readings, wrap the ring, then clear a full channel.
    offer_request(OP_SAMPLE, 1'b1, '0);
    offer_request(OP_CLEAR, 1'b1, '1);
    offer_request(OP_SAMPLE, 1'b1, '1);
    for (int i = 0; i < SAMPLES; i++) begin
      offer_request(OP_SAMPLE, 1'b0, '1);
    end
    offer_request(OP_SAMPLE, 1'b0, '0);
    offer_request(OP_CLEAR, 1'b0, 10'h155);

    // Random part: mostly bursts of 4 to 40 samples on one channel, each with a
    // value profile, plus clears and loose noise.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // Ask once for the long hold-off; bursts may step over any fixed count.
      if (!held && sent >= 150) begin
        hold_off_go = 1'b1;
        held        = 1'b1;
      end
      steady = (sent >= 400 && sent < 600);
      kind = $urandom_range(99);
      if (kind < 82) begin
        run_ch  = 1'($urandom_range(1));
        run_len = $urandom_range(4, 40);
        profile = $urandom_range(3);
        case ($urandom_range(2))
          0:       level = '0;
          1:       level = '1;
          default: level = SAMPLE_W'($urandom_range(1023));
        endcase
        for (int i = 0; i < run_len; i++) begin
          case (profile)
            0:       value = SAMPLE_W'($urandom_range(1023));
            1:       value = SAMPLE_W'($urandom_range(15));
            2:       value = SAMPLE_W'($urandom_range(1008, 1023));
            default: value = level;
          endcase
          // Slip in the other channel now and then.
          ch = ($urandom_range(99) < 20) ? ~run_ch : run_ch;
          offer_request(OP_SAMPLE, ch, value);
          sent++;
        end
      end else if (kind < 90) begin
        offer_request(OP_CLEAR, 1'($urandom_range(1)), SAMPLE_W'($urandom_range(1023)));
        sent++;
      end else begin
        offer_request(($urandom_range(7) == 0) ? OP_CLEAR : OP_SAMPLE,
                      1'($urandom_range(1)), SAMPLE_W'($urandom_range(1023)));
        sent++;
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Drain: let the checker log the last request, wait for every owed
    // result, then give the block time to show anything extra.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("channel_moving_average_minmax_unit: match");
    end else begin
      $display("channel_moving_average_minmax_unit: mismatch");
    end
    $finish;
  end

endmodule
